### rtl/core/tpl_pkg.sv
// ----------------------------------------------------------------------------
// tpl_pkg
// Shared constants, types and helpers of the tag pair line matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package tpl_pkg;

    // Default sizes of the block.
    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_NAME_LEN    = 19;
    localparam int DEF_LINE_BITS   = 20;

    // Width of the entry index field on the result stream.
    localparam int INDEX_W = 6;

    // Character codes that steer the tag parser.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OPEN      = 2'd0,
        STAT_MATCH     = 2'd1,
        STAT_UNMATCHED = 2'd2,
        STAT_FULL      = 2'd3
    } tpl_status_t;

    // What the parser makes of the current character, merged with the line so far.
    typedef struct packed {
        logic closing;
        logic overflow;
        logic append;
    } tpl_scan_flags_t;

    // Address width for a store of the given depth, at least one bit.
    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

### rtl/core/tpl_ram.sv
// ----------------------------------------------------------------------------
// tpl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tpl_ram
    import tpl_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = addr_bits(DEPTH)
)
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### rtl/core/tpl_char_scan.sv
// ----------------------------------------------------------------------------
// tpl_char_scan
// Per-character tag parser and collector of the current line's tag name.
// ----------------------------------------------------------------------------
`default_nettype none

module tpl_char_scan
    import tpl_pkg::*;
#(
    parameter int NAME_LEN = DEF_NAME_LEN,
    localparam int CW = $clog2(NAME_LEN + 1)
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            take,
    input  wire logic [7:0]      ch,
    input  wire logic            line_end,
    input  wire logic            hold_count,
    input  wire logic            clear_count,
    input  wire logic [CW-1:0]   rd_idx,
    output logic      [CW-1:0]   count,
    output logic      [CW-1:0]   count_after,
    output tpl_scan_flags_t      flags,
    output logic      [7:0]      rd_byte
);

    localparam int NIW = addr_bits(NAME_LEN);

    logic          in_tag_reg, in_tag_next;
    logic          closing_reg, closing_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    name_chars [NAME_LEN];

    logic enter;
    logic leave;
    logic set_closing;
    logic set_ovf;
    logic append;

    // Classify the incoming character; a zero byte is ignored.
    always_comb
    begin
        enter       = 1'b0;
        leave       = 1'b0;
        set_closing = 1'b0;
        set_ovf     = 1'b0;
        append      = 1'b0;
        if (take && (ch != CH_NUL))
        begin
            priority if (!in_tag_reg)
            begin
                enter = (ch == CH_LT);
            end
            else if (ch == CH_SLASH)
            begin
                set_closing = 1'b1;
            end
            else if ((ch == CH_TAB) || (ch == CH_SPACE) || (ch == CH_GT))
            begin
                leave = 1'b1;
            end
            else if (count_reg < CW'(NAME_LEN))
            begin
                append = 1'b1;
            end
            else
            begin
                set_ovf = 1'b1;
            end
        end
    end

    // Line flags including the current character.
    always_comb
    begin
        flags.closing  = closing_reg | set_closing;
        flags.overflow = ovf_reg | set_ovf;
        flags.append   = append;
    end

    assign count_after = count_reg + CW'(append);

    // Next state: line end clears the line, but a closing line that starts a
    // table walk keeps its length until the walk is done.
    always_comb
    begin
        in_tag_next  = in_tag_reg;
        closing_next = closing_reg;
        ovf_next     = ovf_reg;
        count_next   = count_reg;
        priority if (take && line_end)
        begin
            in_tag_next  = 1'b0;
            closing_next = 1'b0;
            ovf_next     = 1'b0;
            count_next   = (flags.closing && hold_count) ? count_after : '0;
        end
        else if (take)
        begin
            in_tag_next  = enter ? 1'b1 : (leave ? 1'b0 : in_tag_reg);
            closing_next = flags.closing;
            ovf_next     = flags.overflow;
            count_next   = count_after;
        end
        else if (clear_count)
        begin
            count_next = '0;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tag_reg  <= 1'b0;
            closing_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            in_tag_reg  <= in_tag_next;
            closing_reg <= closing_next;
            ovf_reg     <= ovf_next;
            count_reg   <= count_next;
        end
    end

    // Name buffer, one byte appended per character.
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            name_chars[count_reg[NIW-1:0]] <= ch;
        end
    end

    assign rd_byte = name_chars[rd_idx[NIW-1:0]];
    assign count   = count_reg;

endmodule

`default_nettype wire

### rtl/core/tag_pair_line_matcher_unit.sv
// ----------------------------------------------------------------------------
// tag_pair_line_matcher_unit
// Pairs opening and closing tag lines and keeps a table of tag names.
// ----------------------------------------------------------------------------
// The block takes one character per cycle. Characters inside a line, and the
// last character of an opening line, are taken back to back: the name bytes go
// into the name table while they arrive, so an opening line is recorded in the
// cycle of its last character. The last character of a closing line starts a
// walk of the table, one byte compare per cycle through the single read port
// of the name memory, and input stalls until it ends. Each entry visited
// passes S_LEN, which reads its length and start line, then S_CMP, which
// leaves it at once when the lengths differ and else compares bytes until
// one differs or the whole name matches. A line with no entries yet answers
// at once. When a line ends while the previous result has not been taken,
// its result waits in a holding register and input stalls until the output
// register frees. The table needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tag_pair_line_matcher_unit
    import tpl_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int NAME_LEN    = DEF_NAME_LEN,
    parameter int LINE_BITS   = DEF_LINE_BITS,
    localparam int S_W = ((8 + LINE_BITS + 7) / 8) * 8,
    localparam int M_W = ((INDEX_W + LINE_BITS + 7) / 8) * 8
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    // Input stream.
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [S_W-1:0] s_tdata,   // ch, line_number, zero pad
    input  wire logic           s_tlast,   // line_end
    // Result stream.
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic      [M_W-1:0] m_tdata,   // entry_index, start_line, zero pad
    output logic      [2:0]     m_tuser    // status, name_truncated
);

    localparam int EW         = addr_bits(MAX_ENTRIES);
    localparam int ECW        = $clog2(MAX_ENTRIES + 1);
    localparam int CW         = $clog2(NAME_LEN + 1);
    localparam int BYTE_DEPTH = MAX_ENTRIES * NAME_LEN;
    localparam int RAW        = addr_bits(BYTE_DEPTH);
    localparam int BW         = $clog2(BYTE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_STREAM,
        S_LEN,
        S_CMP,
        S_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [ECW-1:0]       entry_count_reg, entry_count_next;
    logic [BW-1:0]        name_base_reg, name_base_next;
    logic [EW-1:0]        srch_entry_reg, srch_entry_next;
    logic [BW-1:0]        srch_base_reg, srch_base_next;
    logic [CW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic [LINE_BITS-1:0] line_hold_reg, line_hold_next;
    logic                 trunc_hold_reg, trunc_hold_next;
    tpl_status_t          res_status_reg, res_status_next;
    logic [INDEX_W-1:0]   res_index_reg, res_index_next;
    logic [LINE_BITS-1:0] res_start_reg, res_start_next;
    logic                 res_trunc_reg, res_trunc_next;
    logic                 m_valid_reg, m_valid_next;
    tpl_status_t          m_status_reg, m_status_next;
    logic [INDEX_W-1:0]   m_index_reg, m_index_next;
    logic [LINE_BITS-1:0] m_start_reg, m_start_next;
    logic                 m_trunc_reg, m_trunc_next;

    logic [7:0]           ch;
    logic [LINE_BITS-1:0] line;
    logic                 s_accept;
    logic                 out_free;
    logic                 full;
    logic                 last_entry;

    logic                 fire;
    tpl_status_t          fire_status;
    logic [INDEX_W-1:0]   fire_index;
    logic [LINE_BITS-1:0] fire_start;
    logic                 fire_trunc;
    logic                 advance;
    logic                 len_wr_en;
    logic                 byte_wr_en;
    logic                 clear_count;

    logic [CW-1:0]        name_count;
    logic [CW-1:0]        count_after;
    tpl_scan_flags_t      flags;
    logic [7:0]           name_byte;
    logic [CW-1:0]        len_rdata;
    logic [LINE_BITS-1:0] start_rdata;
    logic [7:0]           byte_rdata;
    logic [BW-1:0]        rd_off;

    assign ch       = s_tdata[7:0];
    assign line     = s_tdata[8 +: LINE_BITS];
    assign s_tready = (state_reg == S_STREAM);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign full     = (entry_count_reg == ECW'(MAX_ENTRIES));
    assign last_entry = ((ECW'(srch_entry_reg) + ECW'(1)) == entry_count_reg);

    // Tag parser and name buffer.
    tpl_char_scan #(
        .NAME_LEN (NAME_LEN)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (s_accept),
        .ch          (ch),
        .line_end    (s_tlast),
        .hold_count  (entry_count_reg != '0),
        .clear_count (clear_count),
        .rd_idx      (cmp_idx_reg),
        .count       (name_count),
        .count_after (count_after),
        .flags       (flags),
        .rd_byte     (name_byte)
    );

    // Name bytes are written into the next free slot as they arrive.
    assign byte_wr_en = s_accept && flags.append && !full;
    assign rd_off     = (state_reg == S_CMP) ? (BW'(cmp_idx_reg) + BW'(1)) : '0;

    tpl_ram #(
        .WIDTH (8),
        .DEPTH (BYTE_DEPTH)
    ) u_name_ram (
        .clk     (clk),
        .wr_en   (byte_wr_en),
        .wr_addr (RAW'(name_base_reg + BW'(name_count))),
        .wr_data (ch),
        .rd_addr (RAW'(srch_base_reg + rd_off)),
        .rd_data (byte_rdata)
    );

    tpl_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_ENTRIES)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (len_wr_en),
        .wr_addr (EW'(entry_count_reg)),
        .wr_data (count_after),
        .rd_addr (srch_entry_reg),
        .rd_data (len_rdata)
    );

    tpl_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_start_ram (
        .clk     (clk),
        .wr_en   (len_wr_en),
        .wr_addr (EW'(entry_count_reg)),
        .wr_data (line),
        .rd_addr (srch_entry_reg),
        .rd_data (start_rdata)
    );

    // Line-end handling, table walk and result delivery.
    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        name_base_next   = name_base_reg;
        srch_entry_next  = srch_entry_reg;
        srch_base_next   = srch_base_reg;
        cmp_idx_next     = cmp_idx_reg;
        line_hold_next   = line_hold_reg;
        trunc_hold_next  = trunc_hold_reg;
        res_status_next  = res_status_reg;
        res_index_next   = res_index_reg;
        res_start_next   = res_start_reg;
        res_trunc_next   = res_trunc_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_index_next     = m_index_reg;
        m_start_next     = m_start_reg;
        m_trunc_next     = m_trunc_reg;
        fire             = 1'b0;
        fire_status      = STAT_OPEN;
        fire_index       = '0;
        fire_start       = line;
        fire_trunc       = flags.overflow;
        advance          = 1'b0;
        len_wr_en        = 1'b0;
        clear_count      = 1'b0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_STREAM:
            begin
                if (s_accept && s_tlast)
                begin
                    if (!flags.closing)
                    begin
                        // Opening line: record it, or report a full table.
                        fire = 1'b1;
                        if (full)
                        begin
                            fire_status = STAT_FULL;
                        end
                        else
                        begin
                            fire_status      = STAT_OPEN;
                            fire_index       = INDEX_W'(entry_count_reg);
                            len_wr_en        = 1'b1;
                            entry_count_next = entry_count_reg + ECW'(1);
                            name_base_next   = name_base_reg + BW'(NAME_LEN);
                        end
                    end
                    else
                    begin
                        // Closing line: walk the table unless it is empty.
                        line_hold_next  = line;
                        trunc_hold_next = flags.overflow;
                        if (entry_count_reg == '0)
                        begin
                            fire        = 1'b1;
                            fire_status = STAT_UNMATCHED;
                        end
                        else
                        begin
                            srch_entry_next = '0;
                            srch_base_next  = '0;
                            state_next      = S_LEN;
                        end
                    end
                end
            end
            S_LEN:
            begin
                cmp_idx_next = '0;
                state_next   = S_CMP;
            end
            S_CMP:
            begin
                fire_start = line_hold_reg;
                fire_trunc = trunc_hold_reg;
                priority if (len_rdata != name_count)
                begin
                    advance = 1'b1;
                end
                else if (cmp_idx_reg == name_count)
                begin
                    fire        = 1'b1;
                    fire_status = STAT_MATCH;
                    fire_index  = INDEX_W'(srch_entry_reg);
                    fire_start  = start_rdata;
                end
                else if (byte_rdata != name_byte)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    cmp_idx_next = cmp_idx_reg + CW'(1);
                end

                // Move to the next entry, or give up after the last one.
                if (advance)
                begin
                    if (last_entry)
                    begin
                        fire        = 1'b1;
                        fire_status = STAT_UNMATCHED;
                    end
                    else
                    begin
                        srch_entry_next = srch_entry_reg + EW'(1);
                        srch_base_next  = srch_base_reg + BW'(NAME_LEN);
                        state_next      = S_LEN;
                    end
                end
                clear_count = fire;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = res_index_reg;
                    m_start_next  = res_start_reg;
                    m_trunc_next  = res_trunc_reg;
                    state_next    = S_STREAM;
                end
            end
            default:
            begin
                state_next = S_STREAM;
            end
        endcase

        // A new result goes straight to the output register when it is free.
        if (fire)
        begin
            if (out_free)
            begin
                m_valid_next  = 1'b1;
                m_status_next = fire_status;
                m_index_next  = fire_index;
                m_start_next  = fire_start;
                m_trunc_next  = fire_trunc;
                state_next    = S_STREAM;
            end
            else
            begin
                res_status_next = fire_status;
                res_index_next  = fire_index;
                res_start_next  = fire_start;
                res_trunc_next  = fire_trunc;
                state_next      = S_EMIT;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_STREAM;
            entry_count_reg <= '0;
            name_base_reg   <= '0;
            srch_entry_reg  <= '0;
            srch_base_reg   <= '0;
            cmp_idx_reg     <= '0;
            line_hold_reg   <= '0;
            trunc_hold_reg  <= 1'b0;
            res_status_reg  <= STAT_OPEN;
            res_index_reg   <= '0;
            res_start_reg   <= '0;
            res_trunc_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
            m_status_reg    <= STAT_OPEN;
            m_index_reg     <= '0;
            m_start_reg     <= '0;
            m_trunc_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            name_base_reg   <= name_base_next;
            srch_entry_reg  <= srch_entry_next;
            srch_base_reg   <= srch_base_next;
            cmp_idx_reg     <= cmp_idx_next;
            line_hold_reg   <= line_hold_next;
            trunc_hold_reg  <= trunc_hold_next;
            res_status_reg  <= res_status_next;
            res_index_reg   <= res_index_next;
            res_start_reg   <= res_start_next;
            res_trunc_reg   <= res_trunc_next;
            m_valid_reg     <= m_valid_next;
            m_status_reg    <= m_status_next;
            m_index_reg     <= m_index_next;
            m_start_reg     <= m_start_next;
            m_trunc_reg     <= m_trunc_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_W'({m_start_reg, m_index_reg});
    assign m_tuser  = {m_trunc_reg, m_status_reg};

`ifndef SYNTHESIS
    // The table never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= ECW'(MAX_ENTRIES))
    else $error("entry count beyond table size");

    // The walk only visits recorded entries.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (ECW'(srch_entry_reg) < entry_count_reg))
    else $error("table walk past the last entry");

    // A closing line with entries stalls the input for the walk.
    a_walk_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tlast && flags.closing && (entry_count_reg != '0))
        |=> !s_tready)
    else $error("input not stalled for table walk");

    // A full-table answer only appears once every entry is taken.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_status_reg == STAT_FULL)) |-> full)
    else $error("table full reported with free entries");

    // A recorded opening always leaves at least one entry behind.
    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_status_reg == STAT_OPEN)) |-> (entry_count_reg != '0))
    else $error("opening reported with empty table");
`endif

endmodule

`default_nettype wire

### sim/tag_pair_line_matcher_unit_tb.sv
// ----------------------------------------------------------------------------
// tag_pair_line_matcher_unit_tb
// Self-checking bench for the tag pair line matcher.
//
// A queue of character requests is filled first. It begins with a few
// hand-made lines, then adds random opening, closing, noise and broken lines
// built from a small pool of tag names. A clocked driver sends the requests
// with random gaps. A clocked monitor keeps a line-level model of the parser
// and the name table. The model predicts the outcome of every line, and the
// monitor compares each result field by field while it stalls the result
// stream at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tag_pair_line_matcher_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpl_pkg::*;

    localparam int MAX_ENTRIES  = DEF_MAX_ENTRIES;
    localparam int NAME_LEN     = DEF_NAME_LEN;
    localparam int LINE_W       = DEF_LINE_BITS;
    localparam int S_W          = ((8 + LINE_W + 7) / 8) * 8;
    localparam int M_W          = ((INDEX_W + LINE_W + 7) / 8) * 8;
    localparam int RANDOM_CHARS = 1800;
    localparam int POOL_SIZE    = 16;
    localparam int DRAIN_CYCLES = 50;
    // The limit leaves room for closing lines that walk every entry.
    localparam int CYCLE_LIMIT  = 2_000_000;

    typedef struct {
        logic [7:0]        ch;
        logic              last;
        logic [LINE_W-1:0] line_no;
    } char_req_t;

    typedef struct {
        tpl_status_t        status;
        logic [INDEX_W-1:0] index;
        logic [LINE_W-1:0]  start_line;
        logic               truncated;
    } line_result_t;

    typedef logic [7:0] byte_q_t[$];

    logic           clk      = 1'b0;
    logic           rst_n    = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;   // ch, line_number, zero pad
    logic           s_tlast  = 1'b0; // line_end
    logic           m_tvalid;
    logic           m_tready = 1'b1;
    logic [M_W-1:0] m_tdata;         // entry_index, start_line, zero pad
    logic [2:0]     m_tuser;         // status, name_truncated

    tag_pair_line_matcher_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Stimulus and expectations.
    char_req_t    char_reqs[$];
    line_result_t line_outcomes[$];
    byte_q_t      name_pool[POOL_SIZE];
    byte_q_t      line_buf;
    char_req_t    req;
    line_result_t want;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int line_count     = 0;
    int char_count     = 0;
    int send_gap       = 0;
    int recv_stall     = 0;
    int stall_draw;
    bit send_burst     = 1'b0;
    bit recv_burst     = 1'b0;
    int n_open, n_match, n_unmatched, n_full, n_trunc;

    // Model state of the parser and the name table.
    logic              in_tag_m      = 1'b0;
    logic              closing_m     = 1'b0;
    logic              overflow_m    = 1'b0;
    int unsigned       name_len_m    = 0;
    logic [7:0]        name_buf_m[NAME_LEN];
    logic [7:0]        tbl_name[MAX_ENTRIES][NAME_LEN];
    int unsigned       tbl_len[MAX_ENTRIES];
    logic [LINE_W-1:0] tbl_start[MAX_ENTRIES];
    logic [LINE_W-1:0] tbl_end[MAX_ENTRIES];
    int unsigned       tbl_count     = 0;

    // Clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d line outcomes outstanding.",
                     cycle_count, line_outcomes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // A byte that may stand inside a tag name.
    function automatic logic [7:0] name_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_SLASH || c == CH_TAB || c == CH_SPACE || c == CH_GT);
        return c;
    endfunction

    // Any byte but the one that opens a tag.
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_LT);
        return c;
    endfunction

    // Append a pool name to the line, or a fresh random name for a negative index.
    task automatic put_name(input int idx);
        int n;
        if (idx < 0)
        begin
            n = $urandom_range(1, 4);
            repeat (n) line_buf.push_back(name_char());
        end
        else
        begin
            foreach (name_pool[idx][k])
                line_buf.push_back(name_pool[idx][k]);
        end
    endtask

    // Move the assembled line into the request queue, flagging its last byte.
    task automatic emit_line(input logic [LINE_W-1:0] line_no);
        char_req_t r;
        foreach (line_buf[i])
        begin
            r.ch      = line_buf[i];
            r.last    = (i == line_buf.size() - 1);
            r.line_no = line_no;
            char_reqs.push_back(r);
        end
        line_buf.delete();
        line_count++;
    endtask

    task automatic add_random_line();
        int kind;
        int a;
        int b;
        int n;
        logic [LINE_W-1:0] ln;
        ln   = LINE_W'($urandom_range(0, (1 << LINE_W) - 1));
        kind = $urandom_range(0, 99);
        a    = $urandom_range(0, POOL_SIZE - 1);
        b    = $urandom_range(0, POOL_SIZE - 1);
        if (kind < 40)
        begin
            // Opening line, possibly with leading text and a second tag.
            n = $urandom_range(0, 2);
            repeat (n) line_buf.push_back(text_char());
            line_buf.push_back(CH_LT);
            put_name(a);
            if ($urandom_range(0, 3) == 0)
            begin
                line_buf.push_back(CH_GT);
                line_buf.push_back(CH_LT);
                put_name(b);
            end
            case ($urandom_range(0, 3))
                0: ;
                1: line_buf.push_back(CH_SPACE);
                2: line_buf.push_back(CH_TAB);
                default: line_buf.push_back(CH_GT);
            endcase
            if (line_buf[line_buf.size() - 1] == CH_GT ||
                line_buf[line_buf.size() - 1] == CH_SPACE ||
                line_buf[line_buf.size() - 1] == CH_TAB)
            begin
                n = $urandom_range(0, 2);
                repeat (n) line_buf.push_back(text_char());
            end
        end
        else if (kind < 75)
        begin
            // Closing line, slash first or slash last, sometimes an unknown name.
            if ($urandom_range(0, 4) == 0)
                a = -1;
            line_buf.push_back(CH_LT);
            if ($urandom_range(0, 1) == 1)
            begin
                line_buf.push_back(CH_SLASH);
                if ($urandom_range(0, 6) == 0)
                    line_buf.push_back(CH_NUL);
                put_name(a);
                line_buf.push_back(CH_GT);
            end
            else
            begin
                put_name(a);
                line_buf.push_back(CH_SLASH);
                line_buf.push_back(CH_GT);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                line_buf.push_back(CH_LT);
                put_name(b);
                line_buf.push_back(CH_GT);
            end
        end
        else if (kind < 90)
        begin
            // Plain noise of any byte value.
            n = $urandom_range(1, 8);
            repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            // Broken markup dense in control characters.
            n = $urandom_range(1, 10);
            repeat (n)
            begin
                case ($urandom_range(0, 7))
                    0: line_buf.push_back(CH_LT);
                    1: line_buf.push_back(CH_SLASH);
                    2: line_buf.push_back(CH_GT);
                    3: line_buf.push_back(CH_SPACE);
                    4: line_buf.push_back(CH_TAB);
                    5: line_buf.push_back(CH_NUL);
                    default: line_buf.push_back(name_char());
                endcase
            end
        end
        emit_line(ln);
    endtask

    // Line-level model: feed one accepted byte, queue the outcome at line end.
    task automatic track_char(input logic [7:0] c, input logic last,
                              input logic [LINE_W-1:0] line_no);
        line_result_t r;
        int unsigned  e;
        int unsigned  k;
        bit           hit;
        bit           same;
        if (c != CH_NUL)
        begin
            if (!in_tag_m)
            begin
                if (c == CH_LT)
                    in_tag_m = 1'b1;
            end
            else if (c == CH_SLASH)
                closing_m = 1'b1;
            else if (c == CH_TAB || c == CH_SPACE || c == CH_GT)
                in_tag_m = 1'b0;
            else if (name_len_m < NAME_LEN)
            begin
                name_buf_m[name_len_m] = c;
                name_len_m++;
            end
            else
                overflow_m = 1'b1;
        end
        if (last)
        begin
            r.index      = '0;
            r.start_line = line_no;
            r.truncated  = overflow_m;
            if (!closing_m)
            begin
                if (tbl_count >= MAX_ENTRIES)
                    r.status = STAT_FULL;
                else
                begin
                    for (k = 0; k < name_len_m; k++)
                        tbl_name[tbl_count][k] = name_buf_m[k];
                    tbl_len[tbl_count]   = name_len_m;
                    tbl_start[tbl_count] = line_no;
                    r.status = STAT_OPEN;
                    r.index  = INDEX_W'(tbl_count);
                    tbl_count++;
                end
            end
            else
            begin
                // First entry with an equal name, length included, wins.
                r.status = STAT_UNMATCHED;
                hit = 1'b0;
                for (e = 0; e < tbl_count && !hit; e++)
                begin
                    same = (tbl_len[e] == name_len_m);
                    for (k = 0; k < name_len_m && same; k++)
                        if (tbl_name[e][k] != name_buf_m[k])
                            same = 1'b0;
                    if (same)
                    begin
                        hit          = 1'b1;
                        tbl_end[e]   = line_no;
                        r.status     = STAT_MATCH;
                        r.index      = INDEX_W'(e);
                        r.start_line = tbl_start[e];
                    end
                end
            end
            line_outcomes.push_back(r);
            in_tag_m   = 1'b0;
            closing_m  = 1'b0;
            name_len_m = 0;
            overflow_m = 1'b0;
        end
    endtask

    // Driver: one request per handshake, random gap after each.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tlast    <= 1'b0;
            send_gap   <= 0;
            send_burst <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (char_reqs.size() > 0)
            begin
                req = char_reqs.pop_front();
                s_tdata  <= {{(S_W - 8 - LINE_W){1'b0}}, req.line_no, req.ch};
                s_tlast  <= req.last;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    send_burst <= !send_burst;
                send_gap <= send_burst ? 0 : $urandom_range(0, 10);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: model accepted requests, then check and stall the result stream.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b1;
            recv_stall <= 0;
            recv_burst <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                track_char(s_tdata[7:0], s_tlast, s_tdata[8 +: LINE_W]);
            if (m_tvalid && m_tready)
            begin
                if (line_outcomes.size() == 0)
                    report_mismatch($sformatf("result with no line outcome pending, tuser %0h",
                                              m_tuser));
                else
                begin
                    want = line_outcomes.pop_front();
                    if (m_tuser[1:0] != want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tuser[1:0], want.status));
                    if (m_tdata[INDEX_W-1:0] != want.index)
                        report_mismatch($sformatf("entry_index %0d, expected %0d",
                                                  m_tdata[INDEX_W-1:0], want.index));
                    if (m_tdata[INDEX_W +: LINE_W] != want.start_line)
                        report_mismatch($sformatf("start_line %0h, expected %0h",
                                                  m_tdata[INDEX_W +: LINE_W],
                                                  want.start_line));
                    if (m_tuser[2] != want.truncated)
                        report_mismatch($sformatf("name_truncated %0b, expected %0b",
                                                  m_tuser[2], want.truncated));
                end
                case (tpl_status_t'(m_tuser[1:0]))
                    STAT_OPEN:      n_open++;
                    STAT_MATCH:     n_match++;
                    STAT_UNMATCHED: n_unmatched++;
                    default:        n_full++;
                endcase
                if (m_tuser[2])
                    n_trunc++;
                if ($urandom_range(0, 39) == 0)
                    recv_burst <= !recv_burst;
                stall_draw = recv_burst ? 0 : $urandom_range(0, 10);
                if (stall_draw > 0)
                begin
                    m_tready   <= 1'b0;
                    recv_stall <= stall_draw;
                end
            end
            else if (!m_tready)
            begin
                if (recv_stall <= 1)
                    m_tready <= 1'b1;
                recv_stall <= recv_stall - 1;
            end
        end
    end

    // Stimulus build, reset and end of run.
    initial
    begin
        int len;
        n_open      = 0;
        n_match     = 0;
        n_unmatched = 0;
        n_full      = 0;
        n_trunc     = 0;

        // Name pool; the last three share one prefix of full length, so the
        // two long ones truncate to the same name as the exact-length one.
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            len = (i >= POOL_SIZE - 3) ? NAME_LEN : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
                name_pool[i].push_back((i > POOL_SIZE - 3) ? name_pool[POOL_SIZE - 3][k]
                                                            : name_char());
        end
        name_pool[POOL_SIZE - 2].push_back(name_char());
        repeat (5) name_pool[POOL_SIZE - 1].push_back(name_char());

        // Directed lines: simple open and close at the line number extremes,
        // a line without a tag, a closing line with an empty name, a zero
        // byte carrying the line end, and an unmatched closing line.
        line_buf = '{CH_LT, 8'h61, CH_GT};
        emit_line(20'h00000);
        line_buf = '{CH_LT, CH_SLASH, 8'h61, CH_GT};
        emit_line(20'hFFFFF);
        line_buf = '{8'h78};
        emit_line(20'h5A5A5);
        line_buf = '{CH_LT, CH_SLASH, CH_SPACE, 8'h71};
        emit_line(20'hA5A5A);
        line_buf = '{CH_LT, 8'h62, 8'hFF, CH_NUL};
        emit_line(20'h00001);
        line_buf = '{CH_LT, CH_SLASH, 8'h63, CH_TAB};
        emit_line(20'h80000);

        len = char_reqs.size() + RANDOM_CHARS;
        while (char_reqs.size() < len)
            add_random_line();
        char_count = char_reqs.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (char_reqs.size() > 0 || s_tvalid)
            @(posedge clk);
        while (line_outcomes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d characters in %0d lines over %0d cycles.",
                 char_count, line_count, cycle_count);
        $display("Outcomes: %0d opened, %0d matched, %0d unmatched, %0d table full, %0d truncated.",
                 n_open, n_match, n_unmatched, n_full, n_trunc);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### tag_pair_line_matcher_unit.f
rtl/core/tpl_pkg.sv
rtl/core/tpl_ram.sv
rtl/core/tpl_char_scan.sv
rtl/core/tag_pair_line_matcher_unit.sv
sim/tag_pair_line_matcher_unit_tb.sv
